@@ sv/srpi_pkg.sv @@
// Package for the split-range PI temperature controller: word types, register codes, constants.
`timescale 1ns / 1ps
`default_nettype none
package srpi_pkg;

	localparam int unsigned CFG_IDX_W = 3;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_HEATER_GAIN_NOW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEATER_GAIN_PRIOR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FAN_GAIN_NOW      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FAN_GAIN_PRIOR    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPLIT_THRESHOLD   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HEATER_PERIOD     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FAN_PERIOD        = 3'd6;

	// Register reset values
	localparam logic signed [31:0] RST_HEATER_GAIN_NOW   = 32'sd114568253;
	localparam logic signed [31:0] RST_HEATER_GAIN_PRIOR = -32'sd114567780;
	localparam logic signed [31:0] RST_FAN_GAIN_NOW      = 32'sd29527900;
	localparam logic signed [31:0] RST_FAN_GAIN_PRIOR    = -32'sd29522577;
	localparam logic signed [15:0] RST_SPLIT_THRESHOLD   = 16'sd77;
	localparam logic [31:0]        RST_HEATER_PERIOD     = 32'd50000;
	localparam logic [31:0]        RST_FAN_PERIOD        = 32'd10000000;

	// Duty limits in Q.32: 0.01 and 0.99 (rounded up so the percent reads 99)
	localparam logic [31:0] DUTY_LO = 32'd42949673;
	localparam logic [31:0] DUTY_HI = 32'd4252017624;

	// Saturation limits of the 48-bit accumulators
	localparam logic signed [47:0] ACC_MAX = {1'b0, {47{1'b1}}};
	localparam logic signed [47:0] ACC_MIN = {1'b1, {47{1'b0}}};

	// Scale for whole percents
	localparam logic [32:0] PCT_SCALE = 33'd100;

	typedef struct packed {
		logic signed [15:0] reference_temp;
		logic signed [15:0] measured_temp;
	} in_t;

	typedef struct packed {
		logic [31:0] heater_match;
		logic [31:0] fan_match;
		logic [6:0]  heater_percent;
		logic [6:0]  fan_percent;
		logic        cooling_mode;
	} out_t;

	// Clamp a Q.32 accumulator to the duty window
	function automatic logic [31:0] clamp_duty(input logic signed [47:0] acc);
		logic [31:0] r;
		if (acc < $signed({16'd0, DUTY_LO})) begin
			r = DUTY_LO;
		end else if (acc > $signed({16'd0, DUTY_HI})) begin
			r = DUTY_HI;
		end else begin
			r = acc[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ sv/split_range_pi_temperature_controller.sv @@
// Split-range PI temperature controller: each input word carries a reference and a measured
// temperature (signed Q7.8); the error (reference minus measured) picks heater or fan control
// against split_threshold, the chosen 48-bit accumulator takes an incremental PI step, the other
// side is forced to 1 % duty, and both duties, clamped to 1..99 %, come out as timer match values
// and whole percents with a cooling flag. All multiplication runs through a single registered
// 33x33 signed multiplier under a small sequencer that uses it six times per sample (two gain
// products, two duty-times-period products, two duty-times-100 products). An input word is
// taken only while the sequencer is idle; its result word is handed to the output register at
// the done step, and the next input word can be taken once the sequencer is back in idle. The
// finished result sits in its own output register, so a new sample starts while the previous
// result waits; the last step stalls only when that register is still full. Configuration
// words are always accepted and must be written only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module split_range_pi_temperature_controller
	import srpi_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire in_t                  in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output out_t                      out_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data
);

	// Sequencer steps
	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_ERR       = 4'd1;  // form error, pick side
	localparam logic [3:0] ST_MUL_NOW   = 4'd2;  // gain_now * current error
	localparam logic [3:0] ST_MUL_PRIOR = 4'd3;  // gain_prior * previous error
	localparam logic [3:0] ST_ACC       = 4'd4;  // sum, shift, saturate into accumulator
	localparam logic [3:0] ST_CLAMP     = 4'd5;  // clamp both duties
	localparam logic [3:0] ST_MUL_HM    = 4'd6;  // heater duty * heater period
	localparam logic [3:0] ST_MUL_FM    = 4'd7;  // fan duty * fan period
	localparam logic [3:0] ST_MUL_HP    = 4'd8;  // heater duty * 100
	localparam logic [3:0] ST_MUL_FP    = 4'd9;  // fan duty * 100
	localparam logic [3:0] ST_DONE      = 4'd10; // hand result to output register

	logic [3:0] state_q;

	// Configuration registers
	logic signed [31:0] heater_gain_now_q;
	logic signed [31:0] heater_gain_prior_q;
	logic signed [31:0] fan_gain_now_q;
	logic signed [31:0] fan_gain_prior_q;
	logic signed [15:0] split_threshold_q;
	logic [31:0]        heater_period_q;
	logic [31:0]        fan_period_q;

	// Controller state
	logic signed [16:0] last_error_q;
	logic signed [47:0] heater_acc_q;
	logic signed [47:0] fan_acc_q;

	// Per-sample working registers
	in_t                sample_q;
	logic signed [16:0] err_q;
	logic               cool_q;
	logic signed [63:0] prod_q;
	logic signed [48:0] psum_q;
	logic [31:0]        hd_q;
	logic [31:0]        fd_q;
	out_t               res_q;

	// Output register
	logic out_valid_q;
	out_t out_q;

	logic in_fire;
	logic done_adv;

	// Shared multiplier
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [65:0] mul_p;

	// Error path
	logic signed [16:0] err_d;
	logic signed [16:0] e_now;
	logic signed [16:0] e_prev;

	// Accumulate path
	logic signed [49:0] pi_sum;
	logic signed [45:0] pi_inc;
	logic signed [47:0] acc_sel;
	logic signed [48:0] acc_new;
	logic signed [47:0] acc_sat;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign done_adv  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	assign err_d = {sample_q.reference_temp[15], sample_q.reference_temp}
		- {sample_q.measured_temp[15], sample_q.measured_temp};

	// Cooling runs the PI step on the negated error; the error never reaches -2^16
	assign e_now  = cool_q ? -err_q : err_q;
	assign e_prev = cool_q ? -last_error_q : last_error_q;

	// Operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MUL_NOW: begin
				mul_a = cool_q ? {fan_gain_now_q[31], fan_gain_now_q}
					: {heater_gain_now_q[31], heater_gain_now_q};
				mul_b = {{16{e_now[16]}}, e_now};
			end
			ST_MUL_PRIOR: begin
				mul_a = cool_q ? {fan_gain_prior_q[31], fan_gain_prior_q}
					: {heater_gain_prior_q[31], heater_gain_prior_q};
				mul_b = {{16{e_prev[16]}}, e_prev};
			end
			ST_MUL_HM: begin
				mul_a = {1'b0, hd_q};
				mul_b = {1'b0, heater_period_q};
			end
			ST_MUL_FM: begin
				mul_a = {1'b0, fd_q};
				mul_b = {1'b0, fan_period_q};
			end
			ST_MUL_HP: begin
				mul_a = {1'b0, hd_q};
				mul_b = PCT_SCALE;
			end
			ST_MUL_FP: begin
				mul_a = {1'b0, fd_q};
				mul_b = PCT_SCALE;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Sum the two Q.36 products exactly, drop four bits toward minus infinity, then
	// add into the selected accumulator with saturation at 48 bits
	assign pi_sum  = {psum_q[48], psum_q} + {prod_q[48], prod_q[48:0]};
	assign pi_inc  = pi_sum[49:4];
	assign acc_sel = cool_q ? fan_acc_q : heater_acc_q;
	assign acc_new = {acc_sel[47], acc_sel} + {{3{pi_inc[45]}}, pi_inc};
	assign acc_sat = (acc_new[48] != acc_new[47]) ? (acc_new[48] ? ACC_MIN : ACC_MAX)
		: acc_new[47:0];

	// Control state: sequencer, configuration, previous error, accumulators, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q             <= ST_IDLE;
			out_valid_q         <= 1'b0;
			heater_gain_now_q   <= RST_HEATER_GAIN_NOW;
			heater_gain_prior_q <= RST_HEATER_GAIN_PRIOR;
			fan_gain_now_q      <= RST_FAN_GAIN_NOW;
			fan_gain_prior_q    <= RST_FAN_GAIN_PRIOR;
			split_threshold_q   <= RST_SPLIT_THRESHOLD;
			heater_period_q     <= RST_HEATER_PERIOD;
			fan_period_q        <= RST_FAN_PERIOD;
			last_error_q        <= '0;
			heater_acc_q        <= '0;
			fan_acc_q           <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_HEATER_GAIN_NOW:   heater_gain_now_q   <= cfg_data;
					REG_HEATER_GAIN_PRIOR: heater_gain_prior_q <= cfg_data;
					REG_FAN_GAIN_NOW:      fan_gain_now_q      <= cfg_data;
					REG_FAN_GAIN_PRIOR:    fan_gain_prior_q    <= cfg_data;
					REG_SPLIT_THRESHOLD:   split_threshold_q   <= cfg_data[15:0];
					REG_HEATER_PERIOD:     heater_period_q     <= cfg_data;
					REG_FAN_PERIOD:        fan_period_q        <= cfg_data;
					default: begin
						// drop writes to unknown indexes
					end
				endcase
			end

			// raise valid when a new word lands, drop it once taken
			if (done_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_ERR;
					end
				end
				ST_ERR:       state_q <= ST_MUL_NOW;
				ST_MUL_NOW:   state_q <= ST_MUL_PRIOR;
				ST_MUL_PRIOR: state_q <= ST_ACC;
				ST_ACC: begin
					// forced side goes to 1 % duty
					if (cool_q) begin
						heater_acc_q <= $signed({16'd0, DUTY_LO});
						fan_acc_q    <= acc_sat;
					end else begin
						heater_acc_q <= acc_sat;
						fan_acc_q    <= $signed({16'd0, DUTY_LO});
					end
					last_error_q <= err_q;
					state_q      <= ST_CLAMP;
				end
				ST_CLAMP:  state_q <= ST_MUL_HM;
				ST_MUL_HM: state_q <= ST_MUL_FM;
				ST_MUL_FM: state_q <= ST_MUL_HP;
				ST_MUL_HP: state_q <= ST_MUL_FP;
				ST_MUL_FP: state_q <= ST_DONE;
				ST_DONE: begin
					// hold here while the previous word still waits
					if (done_adv) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_q <= in_data;
		end
		prod_q <= mul_p[63:0];
		case (state_q)
			ST_ERR: begin
				err_q  <= err_d;
				cool_q <= (err_d <= $signed({split_threshold_q[15], split_threshold_q}));
			end
			ST_MUL_PRIOR: psum_q <= prod_q[48:0];
			ST_CLAMP: begin
				hd_q <= clamp_duty(heater_acc_q);
				fd_q <= clamp_duty(fan_acc_q);
				res_q.cooling_mode <= cool_q;
			end
			// product never exceeds the period, so the match cannot wrap
			ST_MUL_FM: res_q.heater_match <= heater_period_q - prod_q[63:32];
			ST_MUL_HP: res_q.fan_match <= fan_period_q - prod_q[63:32];
			// take the fan percent straight off the multiplier so the result is whole
			ST_MUL_FP: {res_q.heater_percent, res_q.fan_percent} <= {prod_q[38:32], mul_p[38:32]};
			ST_DONE: begin
				if (done_adv) begin
					out_q <= res_q;
				end
			end
			default: begin
				// nothing to capture
			end
		endcase
	end

endmodule
`default_nettype wire

@@ sv/srpi_checker.sv @@
// Port-level checker for the split-range PI temperature controller, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module srpi_checker
	import srpi_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire out_t out_data
);

	// A waiting output word holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed or dropped while stalled");

	// The block stays busy right after taking a word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");

	// A new output word appears only at the end of a busy stretch
	a_out_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("output word appeared without work in flight");

	// The forced side reads 1 %, the other side stays within 1..99 %
	a_split_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.cooling_mode ?
			(out_data.heater_percent == 7'd1 && out_data.fan_percent >= 7'd1
				&& out_data.fan_percent <= 7'd99) :
			(out_data.fan_percent == 7'd1 && out_data.heater_percent >= 7'd1
				&& out_data.heater_percent <= 7'd99)))
		else $error("duty percents break the split-range rule");

endmodule

bind split_range_pi_temperature_controller srpi_checker u_srpi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for the split-range PI temperature controller.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import srpi_pkg::*;

	// Index 7 is not a register; writes to it must leave every setting alone
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int CHOKE_CYCLES  = 300;
	localparam int SETTLE_CYCLES = 20;
	localparam int REPORT_LIMIT  = 10;

	// Shapes of random samples: raw noise, errors right at the split point,
	// and runs that stay on the heating or on the cooling side
	typedef enum int {SAMPLE_NOISE, SAMPLE_EDGE, SAMPLE_HEAT, SAMPLE_COOL} sample_kind_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	in_t                  in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_t                 out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data  = '0;

	// Settings as the controller should hold them
	logic signed [31:0] heat_gain_now;
	logic signed [31:0] heat_gain_prev;
	logic signed [31:0] fan_gain_now;
	logic signed [31:0] fan_gain_prev;
	logic signed [15:0] split_thr;
	logic [31:0]        heat_period;
	logic [31:0]        fan_period;

	// Controller state: previous error and both duty accumulators
	logic signed [16:0] prev_error;
	logic signed [47:0] heat_acc;
	logic signed [47:0] fan_acc;

	out_t         due_words[$];
	out_t         head_word;
	int           mismatch_count = 0;
	int           cycle_count    = 0;
	bit           idle_on        = 1'b1;
	bit           choke          = 1'b0;
	int           stall_left     = 0;
	sample_kind_t run_kind       = SAMPLE_NOISE;
	int           run_left       = 0;
	event         choke_go;

	split_range_pi_temperature_controller i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Clamp a Q.32 accumulator into the 1..99 % window
	function automatic logic [31:0] duty_window(input logic signed [47:0] acc);
		if (longint'(acc) < longint'(DUTY_LO))
			return DUTY_LO;
		if (longint'(acc) > longint'(DUTY_HI))
			return DUTY_HI;
		return acc[31:0];
	endfunction

	// Period minus the on time; the on time is the top half of duty times period
	function automatic logic [31:0] timer_match(input logic [31:0] duty,
			input logic [31:0] period);
		logic [63:0] on_ticks;
		on_ticks = {32'd0, duty} * {32'd0, period};
		return period - on_ticks[63:32];
	endfunction

	function automatic logic [6:0] whole_percent(input logic [31:0] duty);
		logic [63:0] scaled;
		scaled = {32'd0, duty} * 64'd100;
		return scaled[38:32];
	endfunction

	// Take one sample through the controller: pick the side, step its
	// accumulator, force the other side to 1 %, and form the output word
	function automatic out_t advance_controller(input in_t s);
		logic signed [16:0] err;
		logic signed [16:0] thr_wide;
		longint             e_now;
		longint             e_prev;
		longint             g_now;
		longint             g_prev;
		longint             acc;
		out_t               r;
		err = {s.reference_temp[15], s.reference_temp}
			- {s.measured_temp[15], s.measured_temp};
		thr_wide = {split_thr[15], split_thr};
		r.cooling_mode = (err <= thr_wide);
		if (r.cooling_mode) begin
			// fan works on the negated error
			e_now  = -longint'(err);
			e_prev = -longint'(prev_error);
			g_now  = longint'(fan_gain_now);
			g_prev = longint'(fan_gain_prev);
			acc    = longint'(fan_acc);
		end else begin
			e_now  = longint'(err);
			e_prev = longint'(prev_error);
			g_now  = longint'(heat_gain_now);
			g_prev = longint'(heat_gain_prev);
			acc    = longint'(heat_acc);
		end
		// Q.36 sum down to Q.32, rounding toward minus infinity
		acc = acc + ((g_now * e_now + g_prev * e_prev) >>> 4);
		if (acc > longint'(ACC_MAX))
			acc = longint'(ACC_MAX);
		else if (acc < longint'(ACC_MIN))
			acc = longint'(ACC_MIN);
		if (r.cooling_mode) begin
			fan_acc  = acc[47:0];
			heat_acc = {16'd0, DUTY_LO};
		end else begin
			heat_acc = acc[47:0];
			fan_acc  = {16'd0, DUTY_LO};
		end
		prev_error = err;
		r.heater_match   = timer_match(duty_window(heat_acc), heat_period);
		r.fan_match      = timer_match(duty_window(fan_acc), fan_period);
		r.heater_percent = whole_percent(duty_window(heat_acc));
		r.fan_percent    = whole_percent(duty_window(fan_acc));
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Offer one word, hold it until taken, then queue what it must produce
	task automatic send_sample(input in_t s);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= s;
		do @(posedge clk); while (!in_ready);
		due_words.push_back(advance_controller(s));
	endtask

	task automatic send_pair(input int ref_t, input int meas_t);
		send_sample(in_t'({16'(ref_t), 16'(meas_t)}));
	endtask

	// Drop valid and wait until every queued word has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (due_words.size() != 0) @(posedge clk);
	endtask

	// One configuration word; valid stays up for a following write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_HEATER_GAIN_NOW:   heat_gain_now  = val;
			REG_HEATER_GAIN_PRIOR: heat_gain_prev = val;
			REG_FAN_GAIN_NOW:      fan_gain_now   = val;
			REG_FAN_GAIN_PRIOR:    fan_gain_prev  = val;
			REG_SPLIT_THRESHOLD:   split_thr      = val[15:0];
			REG_HEATER_PERIOD:     heat_period    = val;
			REG_FAN_PERIOD:        fan_period     = val;
			default: ;
		endcase
	endtask

	// Rewrite every register while idle, then poke the unused index
	task automatic program_regs(input logic [31:0] hg_now, input logic [31:0] hg_prev,
			input logic [31:0] fg_now, input logic [31:0] fg_prev,
			input logic [31:0] thr, input logic [31:0] h_per, input logic [31:0] f_per);
		drain();
		write_reg(REG_HEATER_GAIN_NOW, hg_now);
		write_reg(REG_HEATER_GAIN_PRIOR, hg_prev);
		write_reg(REG_FAN_GAIN_NOW, fg_now);
		write_reg(REG_FAN_GAIN_PRIOR, fg_prev);
		write_reg(REG_SPLIT_THRESHOLD, thr);
		write_reg(REG_HEATER_PERIOD, h_per);
		write_reg(REG_FAN_PERIOD, f_per);
		write_reg(REG_UNUSED, $urandom());
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'd0;
			3: return $urandom();
			// gains near real tuning keep the duty inside the window
			default: return 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
		endcase
	endfunction

	function automatic logic [31:0] pick_prior(input logic [31:0] g_now);
		if ($urandom_range(0, 1) == 0)
			return -g_now + 32'($urandom_range(0, 32'h000F_FFFF));
		return pick_gain();
	endfunction

	function automatic logic [31:0] pick_period();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'hFFFF_FFFF;
			3: return $urandom();
			default: return 32'($urandom_range(1, 100000));
		endcase
	endfunction

	// Upper half carries junk; only the low 16 bits count
	function automatic logic [31:0] pick_threshold();
		logic [15:0] low;
		case ($urandom_range(0, 4))
			0: low = 16'h7FFF;
			1: low = 16'h8000;
			2: low = 16'($urandom());
			default: low = 16'($urandom_range(0, 1024)) - 16'd512;
		endcase
		return {16'($urandom()), low};
	endfunction

	task automatic program_random_regs();
		logic [31:0] hg;
		logic [31:0] fg;
		hg = pick_gain();
		fg = pick_gain();
		program_regs(hg, pick_prior(hg), fg, pick_prior(fg), pick_threshold(),
			pick_period(), pick_period());
	endtask

	// Runs of samples of one shape; errors are chosen first and the
	// temperatures placed so that neither field wraps
	function automatic in_t next_sample();
		in_t s;
		int  e;
		int  lo;
		int  hi;
		int  m;
		if (run_left == 0) begin
			run_left = $urandom_range(1, 20);
			case ($urandom_range(0, 9))
				0, 1:    run_kind = SAMPLE_NOISE;
				2, 3:    run_kind = SAMPLE_EDGE;
				4, 5, 6: run_kind = SAMPLE_HEAT;
				default: run_kind = SAMPLE_COOL;
			endcase
		end
		run_left--;
		case (run_kind)
			SAMPLE_EDGE: e = int'(split_thr) + int'($urandom_range(0, 8)) - 4;
			SAMPLE_HEAT: e = int'(split_thr) + int'($urandom_range(1, 3000));
			SAMPLE_COOL: e = int'(split_thr) - int'($urandom_range(0, 3000));
			default:     e = 0;
		endcase
		if (run_kind == SAMPLE_NOISE) begin
			s.reference_temp = 16'($urandom());
			s.measured_temp  = 16'($urandom());
		end else begin
			lo = (e < 0) ? -32768 - e : -32768;
			hi = (e < 0) ? 32767 : 32767 - e;
			m  = lo + int'($urandom_range(0, hi - lo));
			s.measured_temp  = 16'(m);
			s.reference_temp = 16'(m + e);
		end
		return s;
	endfunction

	// Error close to full scale, positive when heating
	function automatic in_t extreme_sample(input bit heating);
		in_t s;
		s.reference_temp = 16'sh7FFF - 16'($urandom_range(0, 3));
		s.measured_temp  = 16'sh8000 + 16'($urandom_range(0, 3));
		if (!heating) begin
			s.reference_temp = ~s.reference_temp;
			s.measured_temp  = ~s.measured_temp;
		end
		return s;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset settings: zero error, error equal to and just above the split
	// point, full-scale errors both ways, equal extremes, bit patterns
	task automatic test_directed();
		send_pair(0, 0);
		send_pair(77, 0);
		send_pair(78, 0);
		repeat (3) send_pair(32767, -32768);
		repeat (2) send_pair(-32768, 32767);
		send_pair(-32768, -32768);
		send_pair(32767, 32767);
		send_pair(-1, 0);
		send_pair(16'h5555, 16'hAAAA);
		send_pair(16'hAAAA, 16'h5555);
	endtask

	// Threshold at both extremes, periods of zero, one and full scale
	task automatic test_limits();
		program_regs(32'h0100_0000, 32'hFF00_0000, 32'h0100_0000, 32'hFF00_0000,
			32'h0000_7FFF, 32'd0, 32'hFFFF_FFFF);
		send_pair(32767, -32768);
		send_pair(32767, 0);
		send_pair(32767, -1);
		send_pair(0, 0);
		send_pair(-32768, 32767);
		program_regs(32'h0100_0000, 32'hFF00_0000, 32'h0100_0000, 32'hFF00_0000,
			32'hABCD_8000, 32'd1, 32'd0);
		send_pair(-32768, 32767);
		send_pair(-32768, 0);
		send_pair(-32767, 0);
		send_pair(0, 0);
		send_pair(32767, -32768);
	endtask

	// Drive both accumulators into saturation, up and then down
	task automatic test_saturation();
		program_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'd0, pick_period(), pick_period());
		repeat (20) send_sample(extreme_sample(1'b1));
		repeat (20) send_sample(extreme_sample(1'b0));
		program_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'd0, pick_period(), pick_period());
		repeat (20) send_sample(extreme_sample(1'b1));
		repeat (20) send_sample(extreme_sample(1'b0));
	endtask

	task automatic test_random_settings();
		repeat (9) begin
			program_random_regs();
			repeat (60) send_sample(next_sample());
		end
	endtask

	// Hold the output off long enough that the block fills and stalls its input
	task automatic test_backpressure();
		-> choke_go;
		repeat (40) send_sample(next_sample());
	endtask

	// Back to reset settings, no idling on either side
	task automatic test_steady_stream();
		idle_on <= 1'b0;
		program_regs(RST_HEATER_GAIN_NOW, RST_HEATER_GAIN_PRIOR, RST_FAN_GAIN_NOW,
			RST_FAN_GAIN_PRIOR, {16'd0, RST_SPLIT_THRESHOLD}, RST_HEATER_PERIOD,
			RST_FAN_PERIOD);
		repeat (120) send_sample(next_sample());
	endtask

	initial begin
		heat_gain_now  = RST_HEATER_GAIN_NOW;
		heat_gain_prev = RST_HEATER_GAIN_PRIOR;
		fan_gain_now   = RST_FAN_GAIN_NOW;
		fan_gain_prev  = RST_FAN_GAIN_PRIOR;
		split_thr      = RST_SPLIT_THRESHOLD;
		heat_period    = RST_HEATER_PERIOD;
		fan_period     = RST_FAN_PERIOD;
		prev_error     = '0;
		heat_acc       = '0;
		fan_acc        = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_limits();
		test_saturation();
		test_random_settings();
		test_backpressure();
		test_steady_stream();

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// ------------------------------------------------------------------
	// Output side
	// ------------------------------------------------------------------

	// Random stall bursts, or a long hold when choked
	always @(posedge clk) begin
		if (choke) begin
			out_ready <= 1'b0;
		end else if (stall_left != 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			out_ready  <= 1'b0;
			stall_left <= $urandom_range(0, 6);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Count the long hold here so the sender keeps offering words meanwhile
	always begin
		@(choke_go);
		choke <= 1'b1;
		repeat (CHOKE_CYCLES) @(posedge clk);
		choke <= 1'b0;
	end

	task automatic note_mismatch(input out_t want, input out_t got, input bit stray);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT) begin
			if (stray)
				$display("%0t: word with nothing queued: got %p", $realtime, got);
			else
				$display("%0t: wrong word: expected %p got %p", $realtime, want, got);
		end
	endtask

	// Compare each accepted word with the oldest queued prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (due_words.size() == 0) begin
				note_mismatch('0, out_data, 1'b1);
			end else begin
				head_word = due_words.pop_front();
				if (out_data.heater_match !== head_word.heater_match
						|| out_data.fan_match !== head_word.fan_match
						|| out_data.heater_percent !== head_word.heater_percent
						|| out_data.fan_percent !== head_word.fan_percent
						|| out_data.cooling_mode !== head_word.cooling_mode) begin
					note_mismatch(head_word, out_data, 1'b0);
				end
			end
		end
	end

	// Watchdog: stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

endmodule
`default_nettype wire

@@ filelist.f @@
sv/srpi_pkg.sv
sv/split_range_pi_temperature_controller.sv
sv/srpi_checker.sv
sim/testbench.sv
